[sv/vci_pkg.sv]
// ----------------------------------------------------------------------------
// vci_pkg
// Shared types and constants for the video chip register interface.
// ----------------------------------------------------------------------------
`default_nettype none

package vci_pkg;

  localparam int VRAM_ADDR_BITS_DEF = 14;

  // Data port reads from this page bypass the read buffer
  localparam logic [5:0]  PALETTE_PAGE = 6'h3f;
  localparam logic [15:0] ADDR_STEP_ROW = 16'd32;
  localparam logic [15:0] ADDR_STEP_COL = 16'd1;

  typedef enum logic [2:0] {
    OP_BUS_READ  = 3'd0,
    OP_BUS_WRITE = 3'd1,
    OP_VBLANK    = 3'd2,
    OP_PRERENDER = 3'd3,
    OP_SPRITE0   = 3'd4
  } vci_op_t;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic [15:0] vram_address;
  } out_item_t;

  // Item between the register stage and the output stage
  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  reg_index;
    logic [7:0]  write_data;
    logic        vblank;
    logic        sprite0;
    logic        palette;
    logic        nmi;
    logic [15:0] addr;
  } pend_t;

  typedef struct packed {
    logic en;
    logic we;
  } vram_cmd_t;

endpackage

`default_nettype wire

[sv/video_chip_register_interface_core.sv]
// ----------------------------------------------------------------------------
// video_chip_register_interface_core
// CPU-facing register file of a tile video chip with flat video memory.
// ----------------------------------------------------------------------------
// Takes one item per cycle while results are taken; each result passes the
// register stage and then the output register, and waits in the register stage
// while the output holds a result. The input stalls only while an item waits in
// the register stage behind a held result. The accepting edge updates the
// scroll/address, control and flag registers and starts the single-port video
// memory access; the edge that moves the item on combines the registered memory
// byte with the bus latch and read buffer into the output register. Memory
// contents are undefined until written, so no clearing pass runs after reset.
`default_nettype none

module video_chip_register_interface_core #(
  parameter int VRAM_ADDR_BITS = vci_pkg::VRAM_ADDR_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire vci_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output vci_pkg::out_item_t      out_item
);

  // Register stage state (fine X and the remaining control bits feed only
  // the renderer, which lives outside this block)
  logic [14:0] temp_r, temp_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic        toggle_r, toggle_nxt;
  logic        ctrl_inc_r, ctrl_inc_nxt;
  logic [1:0]  mask_r, mask_nxt;
  logic        vblank_r, vblank_nxt;
  logic        nmi_en_r, nmi_en_nxt;
  logic        sprite0_r, sprite0_nxt;

  logic            p_valid_r, p_valid_nxt;
  vci_pkg::pend_t  p_r, p_nxt;

  // Output stage state
  logic [7:0]          latch_r, latch_nxt;
  logic [7:0]          rbuf_r, rbuf_nxt;
  logic                out_valid_r, out_valid_nxt;
  vci_pkg::out_item_t  out_r, out_nxt;

  logic               accept;
  logic               p_move;
  logic [15:0]        cur_step;
  vci_pkg::vram_cmd_t mem_cmd;
  logic [7:0]         mem_q;
  vci_pkg::vci_op_t   op;

  assign op       = vci_pkg::vci_op_t'(in_item.operation);
  assign p_move   = p_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cur_step = cur_r + (ctrl_inc_r ? vci_pkg::ADDR_STEP_ROW : vci_pkg::ADDR_STEP_COL);

  always_comb begin
    temp_nxt     = temp_r;
    cur_nxt      = cur_r;
    toggle_nxt   = toggle_r;
    ctrl_inc_nxt = ctrl_inc_r;
    mask_nxt     = mask_r;
    vblank_nxt   = vblank_r;
    nmi_en_nxt   = nmi_en_r;
    sprite0_nxt  = sprite0_r;
    mem_cmd      = '0;

    p_nxt            = p_r;
    p_nxt.operation  = in_item.operation;
    p_nxt.reg_index  = in_item.reg_index;
    p_nxt.write_data = in_item.write_data;
    p_nxt.vblank     = vblank_r;
    p_nxt.sprite0    = sprite0_r;
    p_nxt.palette    = (cur_r[13:8] == vci_pkg::PALETTE_PAGE);
    p_nxt.nmi        = 1'b0;

    if (accept) begin
      case (op)
        vci_pkg::OP_BUS_READ: begin
          if (in_item.reg_index == vci_pkg::REG_STATUS) begin
            vblank_nxt = 1'b0;
            toggle_nxt = 1'b0;
          end else if (in_item.reg_index == vci_pkg::REG_DATA) begin
            mem_cmd.en = 1'b1;
            cur_nxt    = cur_step;
          end
        end
        vci_pkg::OP_BUS_WRITE: begin
          case (in_item.reg_index)
            vci_pkg::REG_CTRL: begin
              ctrl_inc_nxt    = in_item.write_data[2];
              temp_nxt[11:10] = in_item.write_data[1:0];
              nmi_en_nxt      = in_item.write_data[7];
              p_nxt.nmi       = in_item.write_data[7] && !nmi_en_r && vblank_r;
            end
            vci_pkg::REG_MASK: begin
              mask_nxt = {in_item.write_data[4], in_item.write_data[3]};
            end
            vci_pkg::REG_SCROLL: begin
              if (!toggle_r) begin
                temp_nxt[4:0] = in_item.write_data[7:3];
              end else begin
                temp_nxt[14:12] = in_item.write_data[2:0];
                temp_nxt[9:5]   = in_item.write_data[7:3];
              end
              toggle_nxt = !toggle_r;
            end
            vci_pkg::REG_ADDR: begin
              if (!toggle_r) begin
                temp_nxt[13:8] = in_item.write_data[5:0];
                temp_nxt[14]   = 1'b0;
              end else begin
                temp_nxt[7:0] = in_item.write_data;
                cur_nxt       = {1'b0, temp_r[14:8], in_item.write_data};
              end
              toggle_nxt = !toggle_r;
            end
            vci_pkg::REG_DATA: begin
              mem_cmd.en = 1'b1;
              mem_cmd.we = 1'b1;
              cur_nxt    = cur_step;
            end
            default: begin
            end
          endcase
        end
        vci_pkg::OP_VBLANK: begin
          p_nxt.nmi  = !vblank_r && nmi_en_r;
          vblank_nxt = 1'b1;
        end
        vci_pkg::OP_PRERENDER: begin
          vblank_nxt = 1'b0;
          if (mask_r != 2'b00) begin
            sprite0_nxt = 1'b0;
          end
        end
        vci_pkg::OP_SPRITE0: begin
          sprite0_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    p_nxt.addr = cur_nxt;
  end

  vci_vram #(
    .ADDR_BITS (VRAM_ADDR_BITS)
  ) u_vram (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (cur_r[VRAM_ADDR_BITS-1:0]),
    .wdata (in_item.write_data),
    .rdata (mem_q)
  );

  // Output stage: latch and read buffer resolve here, in item order
  always_comb begin
    latch_nxt = latch_r;
    rbuf_nxt  = rbuf_r;
    out_nxt   = out_r;

    if (p_move) begin
      case (vci_pkg::vci_op_t'(p_r.operation))
        vci_pkg::OP_BUS_READ: begin
          if (p_r.reg_index == vci_pkg::REG_STATUS) begin
            latch_nxt = {p_r.vblank, p_r.sprite0, 1'b0, latch_r[4:0]};
          end else if (p_r.reg_index == vci_pkg::REG_DATA) begin
            if (p_r.palette) begin
              latch_nxt = mem_q;
            end else begin
              latch_nxt = rbuf_r;
              rbuf_nxt  = mem_q;
            end
          end
        end
        vci_pkg::OP_BUS_WRITE: begin
          latch_nxt = p_r.write_data;
        end
        default: begin
        end
      endcase
      out_nxt.read_data    = latch_nxt;
      out_nxt.nmi_request  = p_r.nmi;
      out_nxt.vram_address = p_r.addr;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    p_valid_nxt = p_valid_r;
    if (accept) begin
      p_valid_nxt = 1'b1;
    end else if (p_move) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r      <= '0;
      cur_r       <= '0;
      toggle_r    <= 1'b0;
      ctrl_inc_r  <= 1'b0;
      mask_r      <= '0;
      vblank_r    <= 1'b0;
      nmi_en_r    <= 1'b0;
      sprite0_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      latch_r     <= '0;
      rbuf_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      temp_r      <= temp_nxt;
      cur_r       <= cur_nxt;
      toggle_r    <= toggle_nxt;
      ctrl_inc_r  <= ctrl_inc_nxt;
      mask_r      <= mask_nxt;
      vblank_r    <= vblank_nxt;
      nmi_en_r    <= nmi_en_nxt;
      sprite0_r   <= sprite0_nxt;
      p_valid_r   <= p_valid_nxt;
      latch_r     <= latch_nxt;
      rbuf_r      <= rbuf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= p_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A result only appears from a pending item
  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p_valid_r))
    else $error("result without pending item");

  // Data port accesses advance the address by the selected step
  a_data_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.reg_index == vci_pkg::REG_DATA &&
     (op == vci_pkg::OP_BUS_READ || op == vci_pkg::OP_BUS_WRITE))
    |=> cur_r == $past(cur_step))
    else $error("data port address did not advance");

  // Status read clears vblank and the write toggle
  a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == vci_pkg::OP_BUS_READ && in_item.reg_index == vci_pkg::REG_STATUS)
    |=> !vblank_r && !toggle_r)
    else $error("status read did not clear flags");

  // NMI pulse only when both conditions end up set
  a_nmi_cond: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && p_nxt.nmi) |=> vblank_r && nmi_en_r)
    else $error("nmi pulse without vblank and enable");

endmodule

`default_nettype wire

[sv/vci_vram.sv]
// ----------------------------------------------------------------------------
// vci_vram
// Single-port video memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vci_vram #(
  parameter int ADDR_BITS = vci_pkg::VRAM_ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire vci_pkg::vram_cmd_t    cmd,
  input  wire logic [ADDR_BITS-1:0]  addr,
  input  wire logic [7:0]            wdata,
  output logic      [7:0]            rdata
);

  logic [7:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[test/video_chip_register_interface_checker.sv]
// ----------------------------------------------------------------------------
// video_chip_register_interface_checker
// Watches both channels of the register interface, predicts every result
// from the accepted items and compares the results field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module video_chip_register_interface_checker
  import vci_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_item_t    in_item,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_item_t   out_item,
  output int unsigned      failures,
  output int unsigned      outstanding,
  output logic             data_port_ready
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_BITS  = VRAM_ADDR_BITS_DEF;
  localparam int VRAM_WORDS = 1 << ADDR_BITS;

  logic [7:0]  latch;
  logic [7:0]  read_buf;
  logic [14:0] t_reg;
  logic [15:0] v_reg;
  logic        w_toggle;
  logic [7:0]  ctrl_reg;
  logic [1:0]  render_en;
  logic        in_vblank;
  logic        nmi_on;
  logic        hit_flag;
  logic [7:0]  vram_image [VRAM_WORDS];
  bit          vram_written [VRAM_WORDS];

  out_item_t   bus_results [$];
  out_item_t   next_result;

  // A data-port read touches the byte at the current address
  assign data_port_ready = vram_written[v_reg[ADDR_BITS-1:0]];

  task automatic clear_registers();
    latch     = '0;
    read_buf  = '0;
    t_reg     = '0;
    v_reg     = '0;
    w_toggle  = 1'b0;
    ctrl_reg  = '0;
    render_en = '0;
    in_vblank = 1'b0;
    nmi_on    = 1'b0;
    hit_flag  = 1'b0;
    bus_results.delete();
  endtask

  task automatic apply_cpu_item(input in_item_t item, output out_item_t res);
    logic [7:0]  value;
    logic [7:0]  keep;
    logic [7:0]  mem;
    logic [7:0]  d;
    logic [15:0] step;
    logic        pulse;
    value = '0;
    keep  = '0;
    pulse = 1'b0;
    d     = item.write_data;
    step  = ctrl_reg[2] ? ADDR_STEP_ROW : ADDR_STEP_COL;
    mem   = vram_image[v_reg[ADDR_BITS-1:0]];
    case (item.operation)
      OP_BUS_READ: begin
        if (item.reg_index == REG_STATUS) begin
          keep      = 8'he0;
          value     = {in_vblank, hit_flag, 6'b0};
          in_vblank = 1'b0;
          w_toggle  = 1'b0;
        end else if (item.reg_index == REG_DATA) begin
          keep = 8'hff;
          if (v_reg[13:8] == PALETTE_PAGE) begin
            value = mem;
          end else begin
            value    = read_buf;
            read_buf = mem;
          end
          v_reg = v_reg + step;
        end
        latch = (value & keep) | (latch & ~keep);
      end
      OP_BUS_WRITE: begin
        latch = d;
        case (item.reg_index)
          REG_CTRL: begin
            ctrl_reg     = d;
            t_reg[11:10] = d[1:0];
            if (d[7]) begin
              pulse  = !nmi_on && in_vblank;
              nmi_on = 1'b1;
            end else begin
              nmi_on = 1'b0;
            end
          end
          REG_MASK: render_en = {d[4], d[3]};
          REG_SCROLL: begin
            if (!w_toggle) begin
              t_reg[4:0] = d[7:3];
            end else begin
              t_reg[14:12] = d[2:0];
              t_reg[9:5]   = d[7:3];
            end
            w_toggle = !w_toggle;
          end
          REG_ADDR: begin
            if (!w_toggle) begin
              t_reg[13:8] = d[5:0];
              t_reg[14]   = 1'b0;
            end else begin
              t_reg[7:0] = d;
              v_reg      = {1'b0, t_reg};
            end
            w_toggle = !w_toggle;
          end
          REG_DATA: begin
            vram_image[v_reg[ADDR_BITS-1:0]]   = d;
            vram_written[v_reg[ADDR_BITS-1:0]] = 1'b1;
            v_reg = v_reg + step;
          end
          default: ;
        endcase
      end
      OP_VBLANK: begin
        pulse     = !in_vblank && nmi_on;
        in_vblank = 1'b1;
      end
      OP_PRERENDER: begin
        in_vblank = 1'b0;
        if (render_en != 2'b00) hit_flag = 1'b0;
      end
      OP_SPRITE0: hit_flag = 1'b1;
      default: ;
    endcase
    res.read_data    = latch;
    res.nmi_request  = pulse;
    res.vram_address = v_reg;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (bus_results.size() == 0) begin
      $error("unexpected result: read_data %0h nmi_request %0b vram_address %0h",
             got.read_data, got.nmi_request, got.vram_address);
      failures++;
    end else begin
      want = bus_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        failures++;
      end
      if (got.nmi_request !== want.nmi_request) begin
        $error("nmi_request: expected %0b, got %0b", want.nmi_request, got.nmi_request);
        failures++;
      end
      if (got.vram_address !== want.vram_address) begin
        $error("vram_address: expected %0h, got %0h", want.vram_address, got.vram_address);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_registers();
    end else begin
      // compare first: a result never belongs to an item accepted on the same edge
      if (out_valid && !out_stall) check_result(out_item);
      if (in_valid && !in_stall) begin
        apply_cpu_item(in_item, next_result);
        bus_results.push_back(next_result);
      end
    end
    outstanding = bus_results.size();
  end

endmodule

`default_nettype wire

[test/video_chip_register_interface_core_tb.sv]
// ----------------------------------------------------------------------------
// video_chip_register_interface_core_tb
// Drives CPU bus accesses and renderer events into the register interface:
// a directed opening, address/data bursts, flag and scroll traffic, noise,
// a long output hold-off and a wrapping 16-bit address sweep, under three
// idling mixes. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module video_chip_register_interface_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import vci_pkg::*;

  localparam logic [2:0] REG_OAM_ADDR     = 3'd3;
  localparam logic [2:0] REG_OAM_DATA     = 3'd4;
  localparam logic [2:0] OP_CODE_LAST     = 3'd7;
  localparam int         ITEMS_PER_PHASE  = 20;
  localparam int         LONG_HOLD_CYCLES = 120;
  localparam int         SETTLE_CYCLES    = 16;

  localparam logic [2:0] SETUP_REGS [5] = '{REG_CTRL, REG_MASK, REG_SCROLL, REG_ADDR,
                                            REG_STATUS};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  int unsigned mismatch_count;
  int unsigned results_pending;
  logic        data_port_ready;

  int          sender_idle_pct;
  int          receiver_idle_pct;
  int          hold_requests;
  int          holds_served;
  int unsigned items_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  video_chip_register_interface_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  video_chip_register_interface_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .failures        (mismatch_count),
    .outstanding     (results_pending),
    .data_port_ready (data_port_ready)
  );

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input in_item_t item);
    // never read a video memory byte that was not written yet
    if (item.operation == OP_BUS_READ && item.reg_index == REG_DATA && !data_port_ready)
      item.operation = OP_BUS_WRITE;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cpu_read(input logic [2:0] reg_no);
    send_item('{operation: OP_BUS_READ, reg_index: reg_no, write_data: 8'($urandom)});
  endtask

  task automatic cpu_write(input logic [2:0] reg_no, input logic [7:0] data);
    send_item('{operation: OP_BUS_WRITE, reg_index: reg_no, write_data: data});
  endtask

  task automatic event_item(input logic [2:0] op);
    send_item('{operation: op, reg_index: 3'($urandom), write_data: 8'($urandom)});
  endtask

  // Clear the write toggle, then load both halves of the address
  task automatic set_vram_address(input logic [15:0] addr);
    cpu_read(REG_STATUS);
    cpu_write(REG_ADDR, {2'($urandom), addr[13:8]});
    cpu_write(REG_ADDR, addr[7:0]);
  endtask

  function automatic in_item_t random_cpu_item();
    in_item_t item;
    if ($urandom_range(9, 0) == 0)
      item.operation = 3'($urandom_range(OP_CODE_LAST, OP_SPRITE0 + 1));
    else
      item.operation = 3'($urandom_range(OP_SPRITE0, OP_BUS_READ));
    item.reg_index  = 3'($urandom);
    item.write_data = 8'($urandom);
    return item;
  endfunction

  task automatic directed_items();
    cpu_read(REG_STATUS);
    cpu_read(REG_CTRL);
    cpu_write(REG_CTRL, 8'h80);     // enable outside vblank: no request
    event_item(OP_VBLANK);
    event_item(OP_VBLANK);
    cpu_read(REG_STATUS);
    cpu_write(REG_CTRL, 8'h00);
    event_item(OP_VBLANK);
    cpu_write(REG_CTRL, 8'h83);     // enable inside vblank: request
    event_item(OP_SPRITE0);
    event_item(OP_PRERENDER);       // rendering off keeps the hit flag
    cpu_read(REG_STATUS);
    cpu_write(REG_MASK, 8'h18);
    event_item(OP_PRERENDER);
    cpu_read(REG_STATUS);
    // fine Y lands in bit 14 when the address low byte is loaded on an odd toggle
    cpu_write(REG_SCROLL, 8'hff);
    cpu_write(REG_SCROLL, 8'hff);
    cpu_write(REG_SCROLL, 8'h00);
    cpu_write(REG_ADDR, 8'h00);
    for (int op = OP_SPRITE0 + 1; op <= OP_CODE_LAST; op++) event_item(3'(op));
    cpu_write(REG_STATUS, 8'h5a);
    cpu_write(REG_OAM_ADDR, 8'h00);
    cpu_write(REG_OAM_DATA, 8'hff);
    cpu_write(REG_CTRL, 8'h00);
    set_vram_address(16'h3f00);
    cpu_write(REG_DATA, 8'ha5);
    cpu_write(REG_DATA, 8'h5a);
    set_vram_address(16'h3f00);
    cpu_read(REG_DATA);             // palette page bypasses the buffer
    cpu_read(REG_DATA);
    cpu_write(REG_CTRL, 8'h04);
    set_vram_address(16'h0000);
    cpu_write(REG_DATA, 8'hff);
    cpu_write(REG_DATA, 8'h00);
    set_vram_address(16'h0000);
    repeat (3) cpu_read(REG_DATA);
  endtask

  task automatic memory_scene();
    logic [15:0] base;
    int          n;
    base = 16'($urandom_range(16'h3fff, 0));
    if ($urandom_range(3, 0) == 0) base[13:8] = PALETTE_PAGE;
    if ($urandom_range(1, 0) == 0) cpu_write(REG_CTRL, 8'($urandom));
    n = $urandom_range(8, 1);
    set_vram_address(base);
    repeat (n) cpu_write(REG_DATA, 8'($urandom));
    set_vram_address(base);
    repeat (n + 1) cpu_read(REG_DATA);
  endtask

  task automatic setup_scene();
    repeat ($urandom_range(6, 2)) begin
      if ($urandom_range(3, 0) == 0)
        cpu_read(SETUP_REGS[$urandom_range(4, 0)]);
      else
        cpu_write(SETUP_REGS[$urandom_range(3, 0)], 8'($urandom));
    end
  endtask

  task automatic frame_scene();
    repeat ($urandom_range(6, 2)) begin
      case ($urandom_range(5, 0))
        0: event_item(OP_VBLANK);
        1: event_item(OP_PRERENDER);
        2: event_item(OP_SPRITE0);
        3: cpu_read(REG_STATUS);
        4: cpu_write(REG_CTRL, 8'($urandom));
        default: cpu_write(REG_MASK, 8'($urandom));
      endcase
    end
  endtask

  task automatic random_scene();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: memory_scene();
      4, 5:       setup_scene();
      6, 7:       frame_scene();
      default:    repeat ($urandom_range(6, 2)) send_item(random_cpu_item());
    endcase
  endtask

  // Hold the output long enough to back the block up into its input
  task automatic pressure_burst();
    int saved_pct;
    saved_pct       = sender_idle_pct;
    sender_idle_pct = 0;
    hold_requests++;
    repeat (40) send_item(random_cpu_item());
    sender_idle_pct = saved_pct;
  endtask

  // Step by 32 from 3fe0 to the top of the 16-bit address space and wrap past zero
  task automatic wrap_sweep();
    cpu_write(REG_CTRL, 8'h04);
    set_vram_address(16'h3fe0);
    repeat (1000) cpu_write(REG_DATA, 8'($urandom));
    repeat (8) cpu_read(REG_DATA);  // address above the memory size
    repeat (540) cpu_write(REG_DATA, 8'($urandom));
    repeat (8) cpu_read(REG_DATA);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
      end
    end
  end

  initial begin
    int unsigned target;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_item           = '0;
    hold_requests     = 0;
    items_sent        = 0;
    sender_idle_pct   = 29;
    receiver_idle_pct = 45;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 29;
          receiver_idle_pct = 45;
        end
        1: begin
          sender_idle_pct   = 45;
          receiver_idle_pct = 29;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      if (phase == 0) directed_items();
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_scene();
      if (phase == 0) pressure_burst();
      if (phase == 2) wrap_sweep();
      wait_drained();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
